// File: hdl/fts_pkg.sv
// Package for the frame time smoother: field widths, reset values and
// configuration register indexes. Used by frame_time_smoother.
`default_nettype none
package fts_pkg;

    localparam int WINDOW_MAX_DEF = 64;

    localparam int WIN_W   = 7;
    localparam int DUR_W   = 20;
    localparam int STAMP_W = 48;
    localparam int FRAME_W = 32;
    localparam int CFG_W   = 48;

    localparam logic [WIN_W-1:0]   RST_WINDOW  = 7'd1;
    localparam logic [DUR_W-1:0]   RST_DEFAULT = 20'd16667;
    localparam logic [DUR_W-1:0]   RST_LIMIT   = 20'd200000;
    localparam logic [STAMP_W-1:0] RST_START   = 48'd0;

    typedef enum logic [1:0] {
        CFG_WINDOW  = 2'd0,
        CFG_DEFAULT = 2'd1,
        CFG_LIMIT   = 2'd2,
        CFG_START   = 2'd3
    } t_cfg_idx;

endpackage
`default_nettype wire

// File: hdl/fts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fts_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: hdl/frame_time_smoother.sv
// Frame time smoother: moving average of frame durations over a ring in RAM.
// An accepted word passes through states S_READ, S_DIV (a bit-serial divider of sum by count)
// and S_DONE into the output register; one finished word is buffered at the output.
// A new input word is taken only after the previous one has left S_DONE.
// Reset (synchronous, active low) and every configuration write seed history slot 0;
// input is stalled during the write and during the seed. Depends on fts_pkg, fts_ram.
`default_nettype none
module frame_time_smoother
    import fts_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [CFG_W-1:0]   i_cfg_data,

    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [STAMP_W-1:0] i_timestamp,

    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [DUR_W-1:0]        o_predicted_duration,
    output logic [DUR_W-1:0]        o_measured_duration,
    output logic                    o_spike_replaced,
    output logic [STAMP_W-1:0]      o_elapsed_time,
    output logic [FRAME_W-1:0]      o_frame_count
);

    localparam int AW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W = DUR_W + CNT_W;
    localparam int DIV_W = $clog2(SUM_W + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_DIV,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [WIN_W-1:0]     r_window;
    logic [DUR_W-1:0]     r_default;
    logic [DUR_W-1:0]     r_limit;
    logic [STAMP_W-1:0]   r_start;
    logic                 r_seed_pend;

    logic [AW-1:0]        r_newest;
    logic [CNT_W-1:0]     r_count;
    logic [SUM_W-1:0]     r_sum;
    logic [DUR_W-1:0]     r_last_dur;
    logic [STAMP_W-1:0]   r_last_stamp;
    logic [STAMP_W-1:0]   r_elapsed;
    logic [FRAME_W-1:0]   r_frames;

    logic [DUR_W-1:0]     r_dur;
    logic                 r_spike;
    logic                 r_drop;

    logic [SUM_W-1:0]     r_div_q;
    logic [CNT_W-1:0]     r_div_rem;
    logic [DIV_W-1:0]     r_div_cnt;

    logic                 r_out_valid;
    logic [DUR_W-1:0]     r_out_pred;
    logic [DUR_W-1:0]     r_out_meas;
    logic                 r_out_spike;
    logic [STAMP_W-1:0]   r_out_elapsed;
    logic [FRAME_W-1:0]   r_out_frames;

    logic                 in_take;
    logic                 out_free;
    logic [STAMP_W-1:0]   raw_dur;
    logic                 spike;
    logic [DUR_W-1:0]     dur;
    logic [CNT_W-1:0]     eff_win;
    logic                 drop;
    logic [CNT_W-1:0]     back;
    logic [CNT_W:0]       newest_x;
    logic [CNT_W:0]       oldest_x;
    logic [AW-1:0]        oldest;
    logic [AW-1:0]        next_slot;
    logic [DUR_W-1:0]     rd_data;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [DUR_W-1:0]     mem_wdata;
    logic [SUM_W-1:0]     n_sum;
    logic [CNT_W-1:0]     n_count;
    logic [CNT_W:0]       trial;
    logic                 trial_ge;
    logic [CNT_W:0]       trial_sub;
    logic [DUR_W-1:0]     n_default;
    logic [STAMP_W-1:0]   n_start;

    assign in_take    = i_in_valid && !o_in_stall;
    assign o_in_stall = !(r_state == S_IDLE && !r_seed_pend && !i_cfg_we);
    assign out_free   = !r_out_valid || !i_out_stall;

    // spike rejection
    assign raw_dur = i_timestamp - r_last_stamp;
    assign spike   = raw_dur > {{(STAMP_W-DUR_W){1'b0}}, r_limit};
    assign dur     = spike ? r_last_dur : raw_dur[DUR_W-1:0];

    always_comb begin
        if (r_window == '0) begin
            eff_win = CNT_W'(1);
        end else if (32'(r_window) > 32'(WINDOW_MAX)) begin
            eff_win = CNT_W'(WINDOW_MAX);
        end else begin
            eff_win = CNT_W'(r_window);
        end
    end

    assign drop = r_count >= eff_win;

    // ring addressing
    assign back     = r_count - CNT_W'(1);
    assign newest_x = (CNT_W+1)'(r_newest);
    always_comb begin
        if (newest_x >= {1'b0, back}) begin
            oldest_x = newest_x - {1'b0, back};
        end else begin
            oldest_x = newest_x + (CNT_W+1)'(WINDOW_MAX) - {1'b0, back};
        end
    end
    assign oldest    = oldest_x[AW-1:0];
    assign next_slot = (32'(r_newest) == WINDOW_MAX - 1) ? '0 : r_newest + AW'(1);

    assign mem_we    = (r_seed_pend && !i_cfg_we) || (r_state == S_READ);
    assign mem_waddr = (r_state == S_READ) ? next_slot : '0;
    assign mem_wdata = (r_state == S_READ) ? r_dur : r_default;

    fts_ram #(
        .WIDTH (DUR_W),
        .DEPTH (WINDOW_MAX)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (oldest),
        .o_rdata (rd_data)
    );

    assign n_sum   = r_sum - (r_drop ? SUM_W'(rd_data) : '0) + SUM_W'(r_dur);
    assign n_count = r_drop ? r_count : r_count + CNT_W'(1);

    // restoring divider step, one quotient bit per cycle
    assign trial     = {r_div_rem, r_div_q[SUM_W-1]};
    assign trial_ge  = trial >= {1'b0, r_count};
    assign trial_sub = trial - {1'b0, r_count};

    // values after a configuration write, for the history clear
    assign n_default = (i_cfg_idx == CFG_DEFAULT) ? i_cfg_data[DUR_W-1:0] : r_default;
    assign n_start   = (i_cfg_idx == CFG_START) ? i_cfg_data[STAMP_W-1:0] : r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_window      <= RST_WINDOW;
            r_default     <= RST_DEFAULT;
            r_limit       <= RST_LIMIT;
            r_start       <= RST_START;
            r_seed_pend   <= 1'b1;
            r_newest      <= '0;
            r_count       <= CNT_W'(1);
            r_sum         <= SUM_W'(RST_DEFAULT);
            r_last_dur    <= RST_DEFAULT;
            r_last_stamp  <= RST_START;
            r_elapsed     <= '0;
            r_frames      <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_WINDOW:  r_window  <= i_cfg_data[WIN_W-1:0];
                    CFG_DEFAULT: r_default <= i_cfg_data[DUR_W-1:0];
                    CFG_LIMIT:   r_limit   <= i_cfg_data[DUR_W-1:0];
                    CFG_START:   r_start   <= i_cfg_data[STAMP_W-1:0];
                    default:     r_window  <= r_window;
                endcase
                r_seed_pend  <= 1'b1;
                r_newest     <= '0;
                r_count      <= CNT_W'(1);
                r_sum        <= SUM_W'(n_default);
                r_last_dur   <= n_default;
                r_last_stamp <= n_start;
            end else if (r_seed_pend) begin
                r_seed_pend <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_dur        <= dur;
                        r_spike      <= spike;
                        r_drop       <= drop;
                        r_last_stamp <= i_timestamp;
                        r_state      <= S_READ;
                    end
                end
                S_READ: begin
                    r_sum      <= n_sum;
                    r_count    <= n_count;
                    r_newest   <= next_slot;
                    r_last_dur <= r_dur;
                    r_div_q    <= n_sum;
                    r_div_rem  <= '0;
                    r_div_cnt  <= DIV_W'(SUM_W);
                    r_state    <= S_DIV;
                end
                S_DIV: begin
                    r_div_q   <= {r_div_q[SUM_W-2:0], trial_ge};
                    r_div_rem <= trial_ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
                    r_div_cnt <= r_div_cnt - DIV_W'(1);
                    if (r_div_cnt == DIV_W'(1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_elapsed     <= r_elapsed + STAMP_W'(r_div_q[DUR_W-1:0]);
                        r_frames      <= r_frames + FRAME_W'(1);
                        r_out_pred    <= r_div_q[DUR_W-1:0];
                        r_out_meas    <= r_dur;
                        r_out_spike   <= r_spike;
                        r_out_elapsed <= r_elapsed + STAMP_W'(r_div_q[DUR_W-1:0]);
                        r_out_frames  <= r_frames + FRAME_W'(1);
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_predicted_duration = r_out_pred;
    assign o_measured_duration  = r_out_meas;
    assign o_spike_replaced     = r_out_spike;
    assign o_elapsed_time       = r_out_elapsed;
    assign o_frame_count        = r_out_frames;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != '0 && 32'(r_count) <= WINDOW_MAX)
        else $error("history count out of range");

    a_take_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_state == S_READ)
        else $error("accepted word did not start a history read");

    a_mean_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |-> r_div_q[SUM_W-1:DUR_W] == '0)
        else $error("mean exceeds duration width");

    a_no_seed_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> !r_seed_pend)
        else $error("seed write overlaps history update");

endmodule
`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench for frame_time_smoother: a scripted opening, then random frame ticks under
// changing settings; every result word is checked against a typed script word or
// against a local smoothing model. Depends on fts_pkg and the frame_time_smoother RTL.
module tb_top;
    import fts_pkg::*;

    localparam int RING_DEPTH  = WINDOW_MAX_DEF;
    localparam int RAND_TICKS  = 800;
    localparam int SETTLE_CYC  = 32;
    localparam int HOLD_CYC    = 400;
    localparam int QUIET_LIMIT = 5000;
    localparam int REPORT_MAX  = 10;
    localparam int SCRIPT_ROWS = 28;
    localparam int DUE_DEPTH   = 16;

    typedef struct packed {
        logic [DUR_W-1:0]   predicted;
        logic [DUR_W-1:0]   measured;
        logic               spike;
        logic [STAMP_W-1:0] elapsed;
        logic [FRAME_W-1:0] frames;
    } t_frame_result;

    typedef enum logic {ROW_TICK, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind     kind;
        t_cfg_idx      reg_idx;
        logic [47:0]   value;
        bit            typed;
        t_frame_result want;
    } t_script_row;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    t_cfg_idx           cfg_idx   = CFG_WINDOW;
    logic [CFG_W-1:0]   cfg_data  = '0;
    logic               in_valid  = 1'b0;
    logic [STAMP_W-1:0] in_stamp  = '0;
    logic               out_stall = 1'b0;
    logic               hold_go   = 1'b0;

    logic               o_in_stall;
    logic               o_out_valid;
    logic [DUR_W-1:0]   o_predicted_duration;
    logic [DUR_W-1:0]   o_measured_duration;
    logic               o_spike_replaced;
    logic [STAMP_W-1:0] o_elapsed_time;
    logic [FRAME_W-1:0] o_frame_count;

    // expected words, in order of acceptance
    t_frame_result      due_buf [DUE_DEPTH];
    int unsigned        due_wr = 0;
    int unsigned        due_rd = 0;

    // smoothing model state
    logic [WIN_W-1:0]   cfg_window;
    logic [DUR_W-1:0]   cfg_default;
    logic [DUR_W-1:0]   cfg_limit;
    logic [STAMP_W-1:0] cfg_start;
    logic [DUR_W-1:0]   ring [RING_DEPTH];
    int unsigned        ring_head;
    int unsigned        ring_fill;
    logic [25:0]        ring_sum;
    logic [STAMP_W-1:0] prev_stamp;
    logic [STAMP_W-1:0] elapsed_acc;
    logic [FRAME_W-1:0] frame_acc;

    int mismatches = 0;
    int ticks_sent = 0;
    int reg_writes = 0;
    int spikes     = 0;
    int full_rings = 0;
    int burst_left = 0;
    bit no_gaps    = 1'b0;
    int quiet_cyc  = 0;

    frame_time_smoother DUT (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_we             (cfg_we),
        .i_cfg_idx            (cfg_idx),
        .i_cfg_data           (cfg_data),
        .i_in_valid           (in_valid),
        .o_in_stall           (o_in_stall),
        .i_timestamp          (in_stamp),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (out_stall),
        .o_predicted_duration (o_predicted_duration),
        .o_measured_duration  (o_measured_duration),
        .o_spike_replaced     (o_spike_replaced),
        .o_elapsed_time       (o_elapsed_time),
        .o_frame_count        (o_frame_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // opening script; expected words typed only where obvious
    t_script_row script [SCRIPT_ROWS] = '{
        '{ROW_TICK,  CFG_WINDOW,  48'd16000,  1'b1,
          '{20'd16000,  20'd16000,  1'b0, 48'd16000,  32'd1}},
        '{ROW_TICK,  CFG_WINDOW,  48'd216001, 1'b1,
          '{20'd16000,  20'd16000,  1'b1, 48'd32000,  32'd2}},
        '{ROW_TICK,  CFG_WINDOW,  48'd416001, 1'b1,
          '{20'd200000, 20'd200000, 1'b0, 48'd232000, 32'd3}},
        '{ROW_TICK,  CFG_WINDOW,  48'd0,      1'b1,
          '{20'd200000, 20'd200000, 1'b1, 48'd432000, 32'd4}},
        '{ROW_TICK,  CFG_WINDOW,  48'd0,      1'b1,
          '{20'd0,      20'd0,      1'b0, 48'd432000, 32'd5}},
        '{ROW_TICK,  CFG_WINDOW,  48'hFFFF_FFFF_FFFF, 1'b1,
          '{20'd0,      20'd0,      1'b1, 48'd432000, 32'd6}},
        '{ROW_TICK,  CFG_WINDOW,  48'd15,     1'b1,
          '{20'd16,     20'd16,     1'b0, 48'd432016, 32'd7}},
        '{ROW_WRITE, CFG_WINDOW,  48'd64,               1'b0, '0},
        '{ROW_TICK,  CFG_WINDOW,  48'd1000,             1'b0, '0},
        '{ROW_TICK,  CFG_WINDOW,  48'd2000,             1'b0, '0},
        '{ROW_TICK,  CFG_WINDOW,  48'd1202000,          1'b0, '0},
        '{ROW_TICK,  CFG_WINDOW,  48'd1203000,          1'b0, '0},
        '{ROW_WRITE, CFG_DEFAULT, 48'hF_FFFF,           1'b0, '0},
        '{ROW_WRITE, CFG_LIMIT,   48'hF_FFFF,           1'b0, '0},
        '{ROW_WRITE, CFG_START,   48'hFFFF_FFFF_FFF0,   1'b0, '0},
        '{ROW_TICK,  CFG_WINDOW,  48'h0000_000F_FFEF,   1'b0, '0},
        '{ROW_TICK,  CFG_WINDOW,  48'h0000_001F_FFEF,   1'b0, '0},
        '{ROW_WRITE, CFG_WINDOW,  48'd0,                1'b0, '0},
        '{ROW_WRITE, CFG_LIMIT,   48'd0,                1'b0, '0},
        '{ROW_TICK,  CFG_WINDOW,  48'hFFFF_FFFF_FFF0,   1'b0, '0},
        '{ROW_TICK,  CFG_WINDOW,  48'hFFFF_FFFF_FFF1,   1'b0, '0},
        '{ROW_WRITE, CFG_WINDOW,  48'hABCD_EF12_34FF,   1'b0, '0},
        '{ROW_WRITE, CFG_DEFAULT, 48'd0,                1'b0, '0},
        '{ROW_WRITE, CFG_LIMIT,   48'd1,                1'b0, '0},
        '{ROW_WRITE, CFG_START,   48'd0,                1'b0, '0},
        '{ROW_TICK,  CFG_WINDOW,  48'd1,                1'b0, '0},
        '{ROW_TICK,  CFG_WINDOW,  48'd3,                1'b0, '0},
        '{ROW_TICK,  CFG_WINDOW,  48'd3,                1'b0, '0}
    };

    function automatic void clear_ring();
        for (int i = 0; i < RING_DEPTH; i++) ring[i] = '0;
        ring[0]    = cfg_default;
        ring_head  = 0;
        ring_fill  = 1;
        ring_sum   = 26'(cfg_default);
        prev_stamp = cfg_start;
    endfunction

    function automatic t_frame_result advance_smoother(input logic [STAMP_W-1:0] ts);
        t_frame_result r;
        logic [STAMP_W-1:0] raw;
        int unsigned depth;
        int unsigned oldest;
        raw     = ts - prev_stamp;
        r.spike = raw > 48'(cfg_limit);
        r.measured = r.spike ? ring[ring_head] : raw[DUR_W-1:0];
        prev_stamp = ts;
        if (cfg_window == 0) depth = 1;
        else if (cfg_window > RING_DEPTH) depth = RING_DEPTH;
        else depth = cfg_window;
        if (ring_fill >= depth) begin
            oldest    = (ring_head + RING_DEPTH - (ring_fill - 1)) % RING_DEPTH;
            ring_sum  = ring_sum - 26'(ring[oldest]);
            ring_fill = ring_fill - 1;
        end
        ring_head       = (ring_head + 1) % RING_DEPTH;
        ring[ring_head] = r.measured;
        ring_fill       = ring_fill + 1;
        ring_sum        = ring_sum + 26'(r.measured);
        r.predicted = 20'(ring_sum / ring_fill);
        elapsed_acc = elapsed_acc + 48'(r.predicted);
        frame_acc   = frame_acc + 1;
        r.elapsed   = elapsed_acc;
        r.frames    = frame_acc;
        if (r.spike) spikes++;
        if (ring_fill == RING_DEPTH) full_rings++;
        return r;
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_WINDOW:  cfg_window  = data[WIN_W-1:0];
            CFG_DEFAULT: cfg_default = data[DUR_W-1:0];
            CFG_LIMIT:   cfg_limit   = data[DUR_W-1:0];
            CFG_START:   cfg_start   = data[STAMP_W-1:0];
            default:     ;
        endcase
        clear_ring();
        reg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_tick(input logic [STAMP_W-1:0] ts, input bit typed,
                             input t_frame_result want);
        t_frame_result pred;
        in_valid <= 1'b1;
        in_stamp <= ts;
        do @(posedge clk); while (!in_valid || o_in_stall);
        pred = advance_smoother(ts);
        due_buf[due_wr % DUE_DEPTH] = typed ? want : pred;
        due_wr++;
        ticks_sent++;
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = no_gaps ? 0 : $urandom_range(1, 25);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (due_wr != due_rd);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic reconfigure();
        logic [47:0] junk;
        logic [47:0] v;
        junk = 48'({$urandom, $urandom});
        case ($urandom_range(0, 9))
            0:       v = 1;
            1:       v = RING_DEPTH;
            2:       v = 0;
            3:       v = $urandom_range(RING_DEPTH + 1, 127);
            4, 5:    v = $urandom_range(2, 8);
            default: v = $urandom_range(1, RING_DEPTH);
        endcase
        write_reg(CFG_WINDOW, (junk << WIN_W) | v);
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 5))
                0:       v = 0;
                1:       v = 20'hF_FFFF;
                default: v = $urandom_range(0, 1000000);
            endcase
            write_reg(CFG_DEFAULT, (junk << DUR_W) | v);
        end
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 7))
                0:       v = 0;
                1:       v = 1;
                2:       v = 20'hF_FFFF;
                default: v = $urandom_range(1000, 1000000);
            endcase
            write_reg(CFG_LIMIT, (junk << DUR_W) | v);
        end
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 3))
                0:       v = 0;
                1:       v = 48'hFFFF_FFFF_FFFF - $urandom_range(0, 2000000);
                default: v = 48'({$urandom, $urandom});
            endcase
            write_reg(CFG_START, v);
        end
    endtask

    // receiver: random stall segments, plus a long hold-off on request
    int  hold_left = 0;
    int  seg_left  = 0;
    int  seg_mode  = 0;
    logic hold_go_q = 1'b0;
    always @(posedge clk) begin
        hold_go_q <= hold_go;
        if (hold_go && !hold_go_q) begin
            hold_left <= HOLD_CYC;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            if (seg_left == 0) begin
                seg_mode <= $urandom_range(0, 3);
                seg_left <= $urandom_range(10, 200);
            end else begin
                seg_left <= seg_left - 1;
            end
            case (seg_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ~out_stall;
            endcase
        end
    end

    always @(posedge clk) begin : check_words
        t_frame_result got;
        t_frame_result want;
        logic bad;
        if (rst_n && o_out_valid && !out_stall) begin
            got = {o_predicted_duration, o_measured_duration, o_spike_replaced,
                   o_elapsed_time, o_frame_count};
            if (due_wr == due_rd) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected word: pred=%0d meas=%0d spike=%0b el=%0h fr=%0d",
                             got.predicted, got.measured, got.spike, got.elapsed,
                             got.frames);
            end else begin
                want = due_buf[due_rd % DUE_DEPTH];
                due_rd++;
                bad  = (got.predicted !== want.predicted) ||
                       (got.measured  !== want.measured)  ||
                       (got.spike     !== want.spike)     ||
                       (got.elapsed   !== want.elapsed)   ||
                       (got.frames    !== want.frames);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("mismatch exp: pred=%0d meas=%0d spike=%0b el=%0h fr=%0d",
                                 want.predicted, want.measured, want.spike,
                                 want.elapsed, want.frames);
                        $display("         got: pred=%0d meas=%0d spike=%0b el=%0h fr=%0d",
                                 got.predicted, got.measured, got.spike,
                                 got.elapsed, got.frames);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall) || cfg_we || !rst_n)
            quiet_cyc <= 0;
        else
            quiet_cyc <= quiet_cyc + 1;
        if (quiet_cyc >= QUIET_LIMIT) begin
            $display("watchdog: %0d cycles with no word moving", quiet_cyc);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : stimulus
        int rand_done;
        int phase;
        int phase_len;
        logic [STAMP_W-1:0] stamp;
        rand_done = 0;
        phase     = 0;
        cfg_window  = RST_WINDOW;
        cfg_default = RST_DEFAULT;
        cfg_limit   = RST_LIMIT;
        cfg_start   = RST_START;
        clear_ring();
        elapsed_acc = '0;
        frame_acc   = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i]) begin
            if (script[i].kind == ROW_WRITE) begin
                drain_and_settle();
                write_reg(script[i].reg_idx, script[i].value);
            end else begin
                send_tick(script[i].value, script[i].typed, script[i].want);
                pace_sender();
            end
        end

        while (rand_done < RAND_TICKS) begin
            drain_and_settle();
            reconfigure();
            phase_len = $urandom_range(20, 120);
            no_gaps   = ($urandom_range(0, 3) == 0) || (phase == 1);
            for (int k = 0; k < phase_len && rand_done < RAND_TICKS; k++) begin
                if (phase == 1 && k == 10) hold_go <= 1'b1;
                if (phase == 1 && k == 11) hold_go <= 1'b0;
                if (phase == 2 && k == phase_len / 2) drain_and_settle();
                // mostly plausible frame spacing, some spikes, jumps and rewinds
                case ($urandom_range(0, 19))
                    14, 15:  stamp = prev_stamp + 48'(cfg_limit) + 1 +
                                     48'($urandom_range(0, 5000));
                    16:      stamp = prev_stamp;
                    17:      stamp = 48'({$urandom, $urandom});
                    18:      stamp = prev_stamp - 48'($urandom_range(1, 100000));
                    19:      stamp = prev_stamp + 48'($urandom_range(0, 20));
                    default: stamp = prev_stamp + 48'($urandom_range(0, cfg_limit));
                endcase
                send_tick(stamp, 1'b0, '0);
                rand_done++;
                pace_sender();
            end
            phase++;
        end

        drain_and_settle();
        $display("covered %0d frame ticks over %0d random phases, %0d register writes",
                 ticks_sent, phase, reg_writes);
        $display("spikes replaced: %0d, words with a full 64-deep ring: %0d",
                 spikes, full_rings);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: frame_time_smoother.f
hdl/fts_pkg.sv
hdl/fts_ram.sv
hdl/frame_time_smoother.sv
tb/tb_top.sv
